@@ rtl/y2bgr_pkg.sv @@
// Shared types, register codes and coefficient tables of the YCbCr 4:2:0 to BGR converter.
`timescale 1ns / 1ps
package y2bgr_pkg;

  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam int MICRO              = 1000000;
  localparam int LUMA_SCALE_MICRO   = 1168900;
  localparam int CHROMA_SCALE_MICRO = 1142900;

  // Matrix codes with their own coefficients; everything else is Rec.601.
  localparam logic [7:0] MC_BT709    = 8'd1;
  localparam logic [7:0] MC_FCC      = 8'd4;
  localparam logic [7:0] MC_SMPTE240 = 8'd7;
  localparam logic [7:0] MC_BT2020_A = 8'd9;
  localparam logic [7:0] MC_BT2020_B = 8'd10;

  // Register select on paddr[2].
  localparam logic REG_MATRIX = 1'b0;
  localparam logic REG_RANGE  = 1'b1;

  localparam logic [7:0] MATRIX_CODE_RST = 8'd6;
  localparam logic       FULL_RANGE_RST  = 1'b1;

  typedef enum logic [2:0] {
    MAT_601,
    MAT_709,
    MAT_FCC,
    MAT_240,
    MAT_2020
  } mat_t;

  localparam int NUM_MAT  = 5;
  localparam int NUM_COEF = 4;
  localparam int COEF_RCR = 0;
  localparam int COEF_GCB = 1;
  localparam int COEF_GCR = 2;
  localparam int COEF_BCB = 3;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb_near;
    logic [7:0] cb_horiz;
    logic [7:0] cb_vert;
    logic [7:0] cb_diag;
    logic [7:0] cr_near;
    logic [7:0] cr_horiz;
    logic [7:0] cr_vert;
    logic [7:0] cr_diag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } out_item_t;

  // Luma with range offset applied, and centered upsampled chroma.
  typedef struct packed {
    logic signed [8:0] y_off;
    logic signed [8:0] cb;
    logic signed [8:0] cr;
  } ups_item_t;

  // Round half up of micro * 2^frac / 10^6.
  function automatic logic [63:0] to_fixed(input logic [63:0] micro, input int frac);
    return ((micro << frac) + 64'(MICRO / 2)) / MICRO;
  endfunction

  function automatic logic [63:0] coef_micro(input mat_t m, input int idx);
    logic [63:0] c_rcr;
    logic [63:0] c_gcb;
    logic [63:0] c_gcr;
    logic [63:0] c_bcb;
    logic [63:0] res;
    case (m)
      MAT_709: begin
        c_rcr = 64'd1574800; c_gcb = 64'd187324; c_gcr = 64'd468124; c_bcb = 64'd1855600;
      end
      MAT_FCC: begin
        c_rcr = 64'd1400000; c_gcb = 64'd331864; c_gcr = 64'd711864; c_bcb = 64'd1780000;
      end
      MAT_240: begin
        c_rcr = 64'd1576000; c_gcb = 64'd226622; c_gcr = 64'd476622; c_bcb = 64'd1826000;
      end
      MAT_2020: begin
        c_rcr = 64'd1474600; c_gcb = 64'd164553; c_gcr = 64'd571353; c_bcb = 64'd1881400;
      end
      default: begin
        c_rcr = 64'd1402000; c_gcb = 64'd344136; c_gcr = 64'd714136; c_bcb = 64'd1772000;
      end
    endcase
    case (idx)
      COEF_RCR: res = c_rcr;
      COEF_GCB: res = c_gcb;
      COEF_GCR: res = c_gcr;
      default:  res = c_bcb;
    endcase
    return res;
  endfunction

  function automatic mat_t mat_of_code(input logic [7:0] code);
    mat_t m;
    case (code)
      MC_BT709:                 m = MAT_709;
      MC_FCC:                   m = MAT_FCC;
      MC_SMPTE240:              m = MAT_240;
      MC_BT2020_A, MC_BT2020_B: m = MAT_2020;
      default:                  m = MAT_601;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/y2bgr_upsample.sv @@
// First stage: 9:3:3:1 chroma upsampling and luma range offset.
`timescale 1ns / 1ps
module y2bgr_upsample (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  full_range,
  input  logic                  up_vld,
  input  y2bgr_pkg::in_item_t   up_data,
  output logic                  up_rdy,
  output logic                  dn_vld,
  output y2bgr_pkg::ups_item_t  dn_data,
  input  logic                  dn_rdy
);
  import y2bgr_pkg::*;

  function automatic logic signed [8:0] ups(input logic [7:0] n, input logic [7:0] h,
                                            input logic [7:0] v, input logic [7:0] d);
    logic [11:0] s;
    s = (12'(n) << 3) + 12'(n) + (12'(h) << 1) + 12'(h) + (12'(v) << 1) + 12'(v) +
        12'(d) + 12'd8;
    return $signed({1'b0, s[11:4]}) - 9'sd128;
  endfunction

  logic      vld_r;
  ups_item_t data_r;
  ups_item_t data_nxt;

  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    data_nxt.y_off = full_range ? $signed({1'b0, up_data.luma})
                                : $signed({1'b0, up_data.luma}) - 9'sd16;
    data_nxt.cb    = ups(up_data.cb_near, up_data.cb_horiz, up_data.cb_vert, up_data.cb_diag);
    data_nxt.cr    = ups(up_data.cr_near, up_data.cr_horiz, up_data.cr_vert, up_data.cr_diag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_data = data_r;

endmodule

@@ rtl/y2bgr_matrix.sv @@
// Two multiply stages: matrix coefficients, then range scale.
`timescale 1ns / 1ps
module y2bgr_matrix #(
  parameter int COEF_FRAC_BITS = y2bgr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [7:0]                            matrix_code,
  input  logic                                  full_range,
  input  logic                                  up_vld,
  input  y2bgr_pkg::ups_item_t                  up_data,
  output logic                                  up_rdy,
  output logic                                  dn_vld,
  output logic signed [2*COEF_FRAC_BITS+12:0]   dn_yt,
  output logic signed [2*COEF_FRAC_BITS+12:0]   dn_qb,
  output logic signed [2*COEF_FRAC_BITS+12:0]   dn_qg,
  output logic signed [2*COEF_FRAC_BITS+12:0]   dn_qr,
  input  logic                                  dn_rdy
);
  import y2bgr_pkg::*;

  localparam int KW = COEF_FRAC_BITS + 2;
  localparam int PW = COEF_FRAC_BITS + 11;
  localparam int SW = 2 * COEF_FRAC_BITS + 13;

  localparam logic [KW-1:0] ONE_Q = {2'b01, {COEF_FRAC_BITS{1'b0}}};
  localparam logic [KW-1:0] LS_Q  = KW'(to_fixed(64'(LUMA_SCALE_MICRO), COEF_FRAC_BITS));
  localparam logic [KW-1:0] CS_Q  = KW'(to_fixed(64'(CHROMA_SCALE_MICRO), COEF_FRAC_BITS));

  logic [KW-1:0] ktab [NUM_MAT][NUM_COEF];

  for (genvar m = 0; m < NUM_MAT; m++) begin : g_mat
    for (genvar i = 0; i < NUM_COEF; i++) begin : g_coef
      localparam logic [63:0] KV = to_fixed(coef_micro(mat_t'(m), i), COEF_FRAC_BITS);
      assign ktab[m][i] = KW'(KV);
    end
  end

  mat_t                 sel;
  logic signed [KW-1:0] ks;
  logic signed [KW-1:0] cs;
  logic signed [KW-1:0] k_rcr;
  logic signed [KW-1:0] k_gcb;
  logic signed [KW-1:0] k_gcr;
  logic signed [KW-1:0] k_bcb;

  assign sel   = mat_of_code(matrix_code);
  assign k_rcr = $signed(ktab[sel][COEF_RCR]);
  assign k_gcb = $signed(ktab[sel][COEF_GCB]);
  assign k_gcr = $signed(ktab[sel][COEF_GCR]);
  assign k_bcb = $signed(ktab[sel][COEF_BCB]);
  assign ks    = full_range ? $signed(ONE_Q) : $signed(LS_Q);
  assign cs    = full_range ? $signed(ONE_Q) : $signed(CS_Q);

  // Stage A: luma scale and matrix coefficient products.
  logic                 a_vld_r;
  logic                 a_rdy;
  logic signed [PW-1:0] a_y_r,  a_y_nxt;
  logic signed [PW-1:0] a_b_r,  a_b_nxt;
  logic signed [PW-1:0] a_gb_r, a_gb_nxt;
  logic signed [PW-1:0] a_gr_r, a_gr_nxt;
  logic signed [PW-1:0] a_r_r,  a_r_nxt;

  // Stage B: chroma range scale.
  logic                 b_vld_r;
  logic                 b_rdy;
  logic signed [PW-1:0] g_sum;
  logic signed [SW-1:0] b_yt_r, b_yt_nxt;
  logic signed [SW-1:0] b_qb_r, b_qb_nxt;
  logic signed [SW-1:0] b_qg_r, b_qg_nxt;
  logic signed [SW-1:0] b_qr_r, b_qr_nxt;

  assign b_rdy  = !b_vld_r || dn_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign up_rdy = a_rdy;

  always_comb begin
    a_y_nxt  = PW'(up_data.y_off) * PW'(ks);
    a_b_nxt  = PW'(up_data.cb) * PW'(k_bcb);
    a_gb_nxt = PW'(up_data.cb) * PW'(k_gcb);
    a_gr_nxt = PW'(up_data.cr) * PW'(k_gcr);
    a_r_nxt  = PW'(up_data.cr) * PW'(k_rcr);
  end

  always_comb begin
    g_sum    = a_gb_r + a_gr_r;
    b_yt_nxt = SW'(a_y_r) <<< COEF_FRAC_BITS;
    b_qb_nxt = SW'(a_b_r) * SW'(cs);
    b_qg_nxt = SW'(g_sum) * SW'(cs);
    b_qr_nxt = SW'(a_r_r) * SW'(cs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= up_vld;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_vld) begin
      a_y_r  <= a_y_nxt;
      a_b_r  <= a_b_nxt;
      a_gb_r <= a_gb_nxt;
      a_gr_r <= a_gr_nxt;
      a_r_r  <= a_r_nxt;
    end
    if (b_rdy && a_vld_r) begin
      b_yt_r <= b_yt_nxt;
      b_qb_r <= b_qb_nxt;
      b_qg_r <= b_qg_nxt;
      b_qr_r <= b_qr_nxt;
    end
  end

  assign dn_vld = b_vld_r;
  assign dn_yt  = b_yt_r;
  assign dn_qb  = b_qb_r;
  assign dn_qg  = b_qg_r;
  assign dn_qr  = b_qr_r;

endmodule

@@ rtl/y2bgr_clip.sv @@
// Last stage: sum, round half up, clip to 0..255 and hold the result item.
`timescale 1ns / 1ps
module y2bgr_clip #(
  parameter int COEF_FRAC_BITS = y2bgr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_vld,
  input  logic signed [2*COEF_FRAC_BITS+12:0]  up_yt,
  input  logic signed [2*COEF_FRAC_BITS+12:0]  up_qb,
  input  logic signed [2*COEF_FRAC_BITS+12:0]  up_qg,
  input  logic signed [2*COEF_FRAC_BITS+12:0]  up_qr,
  output logic                                 up_rdy,
  output logic                                 dn_vld,
  output y2bgr_pkg::out_item_t                 dn_data,
  input  logic                                 dn_rdy
);
  import y2bgr_pkg::*;

  localparam int SW = 2 * COEF_FRAC_BITS + 13;
  localparam int TW = SW + 1;
  localparam int SH = 2 * COEF_FRAC_BITS;
  localparam logic signed [TW-1:0] HALF = TW'(64'(1) << (SH - 1));

  function automatic logic [7:0] clip8(input logic signed [TW-1:0] t);
    logic [7:0] res;
    if (t[TW-1]) begin
      res = 8'd0;
    end else if (|t[TW-2:SH+8]) begin
      res = 8'd255;
    end else begin
      res = t[SH+7:SH];
    end
    return res;
  endfunction

  logic                 vld_r;
  out_item_t            data_r;
  out_item_t            data_nxt;
  logic signed [TW-1:0] t_b;
  logic signed [TW-1:0] t_g;
  logic signed [TW-1:0] t_r;

  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    t_b = TW'(up_yt) + TW'(up_qb) + HALF;
    t_g = TW'(up_yt) - TW'(up_qg) + HALF;
    t_r = TW'(up_yt) + TW'(up_qr) + HALF;
    data_nxt.blue  = clip8(t_b);
    data_nxt.green = clip8(t_g);
    data_nxt.red   = clip8(t_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_data = data_r;

endmodule

@@ rtl/ycbcr420_to_bgr_pixel_converter_unit.sv @@
// Top level of the YCbCr 4:2:0 to BGR pixel converter.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid / in_stall  in_item_t: luma, 4 Cb and 4 Cr samples
//  out_      output     out_valid/out_stall  out_item_t: blue, green, red
//  config    input      APB, pready tied 1   matrix_code @0x0, full_range @0x4
//
//  Cycles: one item per clock sustained while out_stall is low; four register
//  stages (upsample, coefficient multiply, range-scale multiply, round/clip),
//  which register each item in that order before out_valid rises.
//  Reset: synchronous rst_n clears all stage valid bits and loads matrix_code 6
//  (Rec.601) and full_range 1; no items are lost or pending after reset.
//  Stalls: each stage holds while its successor is full and stalled, so empty
//  stages still fill; in_stall rises only when all four stages hold items.
//
module ycbcr420_to_bgr_pixel_converter_unit #(
  parameter int COEF_FRAC_BITS = y2bgr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  in_valid,
  input  y2bgr_pkg::in_item_t   in_data,
  output logic                  in_stall,
  // result item channel
  output logic                  out_valid,
  output y2bgr_pkg::out_item_t  out_data,
  input  logic                  out_stall,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import y2bgr_pkg::*;

  localparam int SW = 2 * COEF_FRAC_BITS + 13;

  // Configuration registers: written on the APB access phase.
  logic [7:0] matrix_code_r;
  logic       full_range_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_code_r <= MATRIX_CODE_RST;
      full_range_r  <= FULL_RANGE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MATRIX: matrix_code_r <= pwdata[7:0];
        REG_RANGE:  full_range_r  <= pwdata[0];
        default:    matrix_code_r <= matrix_code_r;
      endcase
    end
  end

  // Read back the addressed register, zero extended.
  always_comb begin
    case (paddr[2])
      REG_RANGE: prdata = {31'd0, full_range_r};
      default:   prdata = {24'd0, matrix_code_r};
    endcase
  end

  // Stage 1: chroma upsampling and luma offset.
  logic      ups_vld;
  logic      ups_rdy;
  logic      in_rdy;
  ups_item_t ups_data;

  y2bgr_upsample u_upsample (
    .clk        (clk),
    .rst_n      (rst_n),
    .full_range (full_range_r),
    .up_vld     (in_valid),
    .up_data    (in_data),
    .up_rdy     (in_rdy),
    .dn_vld     (ups_vld),
    .dn_data    (ups_data),
    .dn_rdy     (ups_rdy)
  );

  assign in_stall = !in_rdy;

  // Stages 2 and 3: coefficient and range-scale products.
  logic                 mat_vld;
  logic                 mat_rdy;
  logic signed [SW-1:0] mat_yt;
  logic signed [SW-1:0] mat_qb;
  logic signed [SW-1:0] mat_qg;
  logic signed [SW-1:0] mat_qr;

  y2bgr_matrix #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_matrix (
    .clk         (clk),
    .rst_n       (rst_n),
    .matrix_code (matrix_code_r),
    .full_range  (full_range_r),
    .up_vld      (ups_vld),
    .up_data     (ups_data),
    .up_rdy      (ups_rdy),
    .dn_vld      (mat_vld),
    .dn_yt       (mat_yt),
    .dn_qb       (mat_qb),
    .dn_qg       (mat_qg),
    .dn_qr       (mat_qr),
    .dn_rdy      (mat_rdy)
  );

  // Stage 4: sum, round and clip into the output register.
  y2bgr_clip #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_clip (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (mat_vld),
    .up_yt   (mat_yt),
    .up_qb   (mat_qb),
    .up_qg   (mat_qg),
    .up_qr   (mat_qr),
    .up_rdy  (mat_rdy),
    .dn_vld  (out_valid),
    .dn_data (out_data),
    .dn_rdy  (!out_stall)
  );

endmodule

@@ sim/ycbcr420_to_bgr_pixel_converter_unit_test.sv @@
// Self-checking regression bench for the YCbCr 4:2:0 to BGR pixel converter.
`timescale 1ns / 1ps
module ycbcr420_to_bgr_pixel_converter_unit_test;
  import y2bgr_pkg::*;

  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DRAIN_CYCLES = 10;
  localparam int PHASE_PIXELS = 150;
  localparam int NUM_PHASES = 13;

  // Byte addresses of the two registers; the register select sits on paddr[2].
  localparam logic [2:0] ADDR_MATRIX = {REG_MATRIX, 2'b00};
  localparam logic [2:0] ADDR_RANGE  = {REG_RANGE, 2'b00};

  // Codes without a matrix of their own; all three fall back to Rec.601.
  localparam logic [7:0] MC_UNLISTED_LO = 8'd0;
  localparam logic [7:0] MC_UNLISTED_HI = 8'd255;
  localparam logic [7:0] MC_BT601_ALT   = 8'd5;

  // Expected-pixel tracker: holds its own copy of the registers, converts each
  // accepted pixel and compares results in order.
  class bgr_pixel_tracker;
    logic [7:0] matrix_code = MATRIX_CODE_RST;
    logic       full_range = FULL_RANGE_RST;
    out_item_t  expected_pixels[$];
    int         fail_count = 0;

    function longint q_of_micro(longint m);
      return (m * (longint'(1) <<< FRAC) + MICRO / 2) / MICRO;
    endfunction

    // 9:3:3:1 bilinear blend of one chroma plane, centered on zero.
    function longint chroma_blend(logic [7:0] n, logic [7:0] h, logic [7:0] v,
                                  logic [7:0] d);
      longint ln, lh, lv, ld;
      ln = n; lh = h; lv = v; ld = d;
      return ((9 * ln + 3 * lh + 3 * lv + ld + 8) >>> 4) - 128;
    endfunction

    // Round half up at 2F fraction bits, then clip to 0..255.
    function logic [7:0] clip_round(longint s);
      longint t;
      t = s + (longint'(1) <<< (2 * FRAC - 1));
      if (t < 0) return 8'd0;
      t = t >>> (2 * FRAC);
      if (t > 255) return 8'd255;
      return t[7:0];
    endfunction

    function out_item_t convert_pixel(in_item_t px);
      longint k_rcr, k_gcb, k_gcr, k_bcb, one, y, cb, cr, yterm, cscale;
      out_item_t res;
      one = longint'(1) <<< FRAC;
      case (matrix_code)
        MC_BT709: begin
          k_rcr = 1574800; k_gcb = 187324; k_gcr = 468124; k_bcb = 1855600;
        end
        MC_FCC: begin
          k_rcr = 1400000; k_gcb = 331864; k_gcr = 711864; k_bcb = 1780000;
        end
        MC_SMPTE240: begin
          k_rcr = 1576000; k_gcb = 226622; k_gcr = 476622; k_bcb = 1826000;
        end
        MC_BT2020_A, MC_BT2020_B: begin
          k_rcr = 1474600; k_gcb = 164553; k_gcr = 571353; k_bcb = 1881400;
        end
        default: begin
          k_rcr = 1402000; k_gcb = 344136; k_gcr = 714136; k_bcb = 1772000;
        end
      endcase
      k_rcr = q_of_micro(k_rcr);
      k_gcb = q_of_micro(k_gcb);
      k_gcr = q_of_micro(k_gcr);
      k_bcb = q_of_micro(k_bcb);
      y = px.luma;
      cb = chroma_blend(px.cb_near, px.cb_horiz, px.cb_vert, px.cb_diag);
      cr = chroma_blend(px.cr_near, px.cr_horiz, px.cr_vert, px.cr_diag);
      if (full_range) begin
        yterm = y * one * one;
        cscale = one;
      end else begin
        yterm = (y - 16) * q_of_micro(LUMA_SCALE_MICRO) * one;
        cscale = q_of_micro(CHROMA_SCALE_MICRO);
      end
      res.blue  = clip_round(yterm + k_bcb * cb * cscale);
      res.green = clip_round(yterm - k_gcb * cb * cscale - k_gcr * cr * cscale);
      res.red   = clip_round(yterm + k_rcr * cr * cscale);
      return res;
    endfunction

    function void note_pixel_in(in_item_t px);
      expected_pixels.push_back(convert_pixel(px));
    endfunction

    function void check_pixel_out(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: blue %0d green %0d red %0d", got.blue, got.green, got.red);
        fail_count++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        fail_count++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        fail_count++;
      end
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 27;
  int recv_idle_pct = 76;
  int cycle_count = 0;

  bgr_pixel_tracker tracker = new();

  ycbcr420_to_bgr_pixel_converter_unit #(
    .COEF_FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the pipe never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ycbcr420_to_bgr_pixel_converter_unit regression: fail");
      $finish;
    end
  end

  // Result side: check the item taken at this edge (pre-edge values), then
  // pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_pixel_out(out_data);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one pixel, idling at random first; hold valid and payload until taken.
  task automatic push_pixel(input in_item_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    tracker.note_pixel_in(px);
  endtask

  // Drop valid and wait until every expected pixel is back.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [2:0] addr, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata @%0d: expected %0d, got %0d", addr, want, prdata);
      tracker.fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program both registers while the pipe is empty, read them back and
  // mirror them in the tracker.
  task automatic set_conversion(input logic [7:0] code, input logic range_full);
    drain_pixels();
    repeat (PIPE_DRAIN_CYCLES) @(posedge clk);
    cfg_write(ADDR_MATRIX, {24'd0, code});
    cfg_write(ADDR_RANGE, {31'd0, range_full});
    cfg_read_check(ADDR_MATRIX, {24'd0, code});
    cfg_read_check(ADDR_RANGE, {31'd0, range_full});
    tracker.matrix_code = code;
    tracker.full_range = range_full;
  endtask

  function automatic logic [7:0] near_sample(int base);
    int v;
    v = base + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Mostly uniform pixels, some smooth-area pixels with close neighbours,
  // some built from rail values only.
  function automatic in_item_t random_pixel();
    in_item_t px;
    int kind, cb_base, cr_base;
    kind = $urandom_range(0, 9);
    px = 72'({$urandom, $urandom, $urandom});
    if (kind >= 6 && kind <= 8) begin
      cb_base = $urandom_range(0, 255);
      cr_base = $urandom_range(0, 255);
      px.cb_near = near_sample(cb_base);
      px.cb_horiz = near_sample(cb_base);
      px.cb_vert = near_sample(cb_base);
      px.cb_diag = near_sample(cb_base);
      px.cr_near = near_sample(cr_base);
      px.cr_horiz = near_sample(cr_base);
      px.cr_vert = near_sample(cr_base);
      px.cr_diag = near_sample(cr_base);
    end else if (kind == 9) begin
      for (int i = 0; i < 9; i++) begin
        px[i*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    end
    return px;
  endfunction

  in_item_t   edge_pixels[$];
  logic [7:0] phase_code[NUM_PHASES];
  logic       phase_full[NUM_PHASES];

  initial begin
    // Rails, neutral gray, primaries at the limits, each neighbour weight
    // alone, and luma below the limited-range floor.
    edge_pixels = '{
      {8'd0, {8{8'd0}}},
      {8'd255, {8{8'd255}}},
      {8'd0, {8{8'd255}}},
      {8'd255, {8{8'd0}}},
      {8'd128, {8{8'd128}}},
      {8'd255, {4{8'd0}}, {4{8'd255}}},
      {8'd255, {4{8'd255}}, {4{8'd0}}},
      {8'd100, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255},
      {8'd100, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0},
      {8'd50, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0},
      {8'd15, {8{8'd128}}},
      {8'd16, {8{8'd128}}},
      {8'd235, {8{8'd240}}}
    };
    phase_code = '{MC_BT709, MC_BT709, MC_FCC, MC_FCC, MC_SMPTE240, MC_BT2020_A,
                   MC_BT2020_B, MC_BT601_ALT, MC_UNLISTED_LO, MC_UNLISTED_HI,
                   MC_UNLISTED_LO, MATRIX_CODE_RST, MATRIX_CODE_RST};
    phase_full = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                   1'b0, 1'b0, 1'b1};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Check the reset values, then run the edge pixels in full range and
    // again in limited range.
    cfg_read_check(ADDR_MATRIX, {24'd0, MATRIX_CODE_RST});
    cfg_read_check(ADDR_RANGE, {31'd0, FULL_RANGE_RST});
    foreach (edge_pixels[i]) push_pixel(edge_pixels[i]);
    set_conversion(MATRIX_CODE_RST, 1'b0);
    foreach (edge_pixels[i]) push_pixel(edge_pixels[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // One phase draws its matrix code at random.
      if (ph == 10) phase_code[ph] = 8'($urandom_range(0, 255));
      set_conversion(phase_code[ph], phase_full[ph]);
      if (ph < 4) begin
        send_idle_pct = 27;
        recv_idle_pct = 76;
      end else if (ph < 8) begin
        send_idle_pct = 76;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // Halfway through, hold off until the pipe is empty.
        if (n == PHASE_PIXELS / 2) drain_pixels();
        push_pixel(random_pixel());
      end
    end

    drain_pixels();
    repeat (PIPE_DRAIN_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("ycbcr420_to_bgr_pixel_converter_unit regression: pass");
    end else begin
      $display("ycbcr420_to_bgr_pixel_converter_unit regression: fail");
    end
    $finish;
  end

endmodule
